/* rtl/lbas_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lbas_pkg;

   // fixed field widths
   localparam int CFG_W       = 11;
   localparam int CSR_IDX_W   = 3;
   localparam int PIX_W       = 8;
   localparam int CHAR_W      = 7;
   localparam int SUM_W       = 28;
   localparam int LUMA_W      = 8;
   localparam int WSUM_W      = 18;
   localparam int RECIP_W     = 19;
   localparam int LUMA_PROD_W = WSUM_W + RECIP_W;
   localparam int LUMA_SHIFT  = 28;
   localparam int SHADE_COUNT = 8;
   localparam int LEVEL_W     = 3;
   localparam int AVG_W       = 8;

   // luma weights, the /1000 is done as a multiply by ceil(2^28/1000)
   localparam logic [WSUM_W-1:0]  LUMA_R     = WSUM_W'(299);
   localparam logic [WSUM_W-1:0]  LUMA_G     = WSUM_W'(587);
   localparam logic [WSUM_W-1:0]  LUMA_B     = WSUM_W'(114);
   localparam logic [RECIP_W-1:0] LUMA_RECIP = RECIP_W'(268436);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IN_WIDTH        = 3'd0,
      REG_IN_HEIGHT       = 3'd1,
      REG_OUT_WIDTH       = 3'd2,
      REG_OUT_HEIGHT      = 3'd3,
      REG_RESIZE_ON       = 3'd4,
      REG_INVERTED_SHADES = 3'd5
   } lbas_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LUMA,
      ST_SUM,
      ST_CNT_MUL,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_EMIT,
      ST_ADV,
      ST_ROW_MUL,
      ST_ROW_GO,
      ST_ROW_WAIT,
      ST_COL_MUL,
      ST_COL_GO,
      ST_COL_WAIT
   } lbas_state_type;

   // operand select of the shared multiplier and divider
   typedef enum logic [1:0] {
      OP_CNT,
      OP_ROW,
      OP_COL
   } lbas_op_type;

   typedef struct packed {
      logic        accept;
      logic        luma_en;
      logic        sum_en;
      logic        mul_en;
      logic        div_start;
      lbas_op_type op;
      logic        load_bound;
      logic        emit;
      logic        advance;
   } lbas_cmd_type;

   typedef struct packed {
      logic cfg_hit;
      logic is_last;
      logic out_free;
      logic adv_col;
      logic adv_row;
      logic div_done;
      logic div_busy;
   } lbas_status_type;

   // shade table "@#%*|-. "
   function automatic logic [CHAR_W-1:0] shade_char(input logic [LEVEL_W-1:0] idx);
      logic [CHAR_W-1:0] c;
      case (idx)
         3'd0:    c = 7'd64;
         3'd1:    c = 7'd35;
         3'd2:    c = 7'd37;
         3'd3:    c = 7'd42;
         3'd4:    c = 7'd124;
         3'd5:    c = 7'd45;
         3'd6:    c = 7'd46;
         default: c = 7'd32;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/lbas_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module lbas_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/lbas_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module lbas_div #(
   parameter int NW   = 30,
   parameter int DENW = 23
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [NW-1:0]   num,
   input  wire logic [DENW-1:0] den,
   output logic                 busy,
   output logic                 done,
   output logic [NW-1:0]        quo
);

   localparam int CW = $clog2(NW + 1);

   logic [DENW-1:0] den_ff;
   logic [DENW-1:0] rem_ff, rem_in;
   logic [NW-1:0]   quo_ff, quo_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DENW:0]   rem_sh;
   logic [DENW+1:0] diff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NW-1]};
      diff    = {1'b0, rem_sh} - {2'b00, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DENW+1]) begin
            rem_in = diff[DENW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DENW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

/* rtl/lbas_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module lbas_dp #(
   parameter int MAX_DIM = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire lbas_pkg::lbas_cmd_type           cmd,
   output lbas_pkg::lbas_status_type             status,
   input  wire logic                             csr_we,
   input  wire logic [lbas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [lbas_pkg::CFG_W-1:0]       csr_wdata,
   input  wire logic [lbas_pkg::PIX_W-1:0]       req_red,
   input  wire logic [lbas_pkg::PIX_W-1:0]       req_green,
   input  wire logic [lbas_pkg::PIX_W-1:0]       req_blue,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [lbas_pkg::CHAR_W-1:0]           rsp_shade_char,
   output logic                                  rsp_row_end,
   output logic                                  rsp_image_end
);

   localparam int DW    = $clog2(MAX_DIM + 1);
   localparam int AW    = $clog2(MAX_DIM);
   localparam int CMPW  = (DW > lbas_pkg::CFG_W) ? DW : lbas_pkg::CFG_W;
   localparam int NW    = (2 * DW + 2 > 30) ? 2 * DW + 2 : 30;
   localparam int DENW  = 2 * DW + 1;
   localparam int PW    = 2 * DW;
   localparam int SW    = lbas_pkg::SUM_W;

   // configuration registers
   logic [lbas_pkg::CFG_W-1:0] in_width_ff, in_height_ff, out_width_ff, out_height_ff;
   logic                       resize_on_ff, inverted_ff;
   logic                       cfg_hit;

   always_comb begin
      cfg_hit = 1'b0;
      if (csr_we) begin
         case (lbas_pkg::lbas_reg_type'(csr_index))
            lbas_pkg::REG_IN_WIDTH,
            lbas_pkg::REG_IN_HEIGHT,
            lbas_pkg::REG_OUT_WIDTH,
            lbas_pkg::REG_OUT_HEIGHT,
            lbas_pkg::REG_RESIZE_ON,
            lbas_pkg::REG_INVERTED_SHADES: cfg_hit = 1'b1;
            default:                       cfg_hit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff   <= lbas_pkg::CFG_W'(1024);
         in_height_ff  <= lbas_pkg::CFG_W'(1024);
         out_width_ff  <= '0;
         out_height_ff <= '0;
         resize_on_ff  <= 1'b0;
         inverted_ff   <= 1'b0;
      end else if (csr_we) begin
         case (lbas_pkg::lbas_reg_type'(csr_index))
            lbas_pkg::REG_IN_WIDTH:        in_width_ff   <= csr_wdata;
            lbas_pkg::REG_IN_HEIGHT:       in_height_ff  <= csr_wdata;
            lbas_pkg::REG_OUT_WIDTH:       out_width_ff  <= csr_wdata;
            lbas_pkg::REG_OUT_HEIGHT:      out_height_ff <= csr_wdata;
            lbas_pkg::REG_RESIZE_ON:       resize_on_ff  <= csr_wdata[0];
            lbas_pkg::REG_INVERTED_SHADES: inverted_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective source and target sizes
   logic [CMPW-1:0] iw_ext, ih_ext, ow_ext, oh_ext, sw_c, sh_c;
   logic            resize_ok;
   logic [DW-1:0]   sw, sh, dw, dh;

   always_comb begin
      iw_ext = CMPW'(in_width_ff);
      ih_ext = CMPW'(in_height_ff);
      ow_ext = CMPW'(out_width_ff);
      oh_ext = CMPW'(out_height_ff);
      if (iw_ext == '0)                      sw_c = CMPW'(1);
      else if (iw_ext > CMPW'(MAX_DIM))      sw_c = CMPW'(MAX_DIM);
      else                                   sw_c = iw_ext;
      if (ih_ext == '0)                      sh_c = CMPW'(1);
      else if (ih_ext > CMPW'(MAX_DIM))      sh_c = CMPW'(MAX_DIM);
      else                                   sh_c = ih_ext;
      resize_ok = resize_on_ff && (ow_ext != '0) && (ow_ext <= sw_c) &&
                  (oh_ext != '0) && (oh_ext <= sh_c);
      sw = sw_c[DW-1:0];
      sh = sh_c[DW-1:0];
      dw = resize_ok ? ow_ext[DW-1:0] : sw;
      dh = resize_ok ? oh_ext[DW-1:0] : sh;
   end

   // luma: weighted sum, then reciprocal multiply
   logic [lbas_pkg::WSUM_W-1:0]      wsum_ff;
   logic [lbas_pkg::LUMA_PROD_W-1:0] luma_prod;
   logic [lbas_pkg::LUMA_W-1:0]      luma_ff;

   assign luma_prod = lbas_pkg::LUMA_PROD_W'(wsum_ff) *
                      lbas_pkg::LUMA_PROD_W'(lbas_pkg::LUMA_RECIP);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         wsum_ff <= lbas_pkg::WSUM_W'(req_red)   * lbas_pkg::LUMA_R +
                    lbas_pkg::WSUM_W'(req_green) * lbas_pkg::LUMA_G +
                    lbas_pkg::WSUM_W'(req_blue)  * lbas_pkg::LUMA_B;
      end
      if (cmd.luma_en) begin
         luma_ff <= luma_prod[lbas_pkg::LUMA_SHIFT +: lbas_pkg::LUMA_W];
      end
   end

   // position counters and cell boundaries
   logic [DW-1:0] col_ff, row_ff, bin_ff, band_ff, cs_ff, rs_ff, ncb_ff, nrb_ff;
   logic [DW-1:0] col_in, row_in, bin_in, band_in, cs_in, rs_in;
   logic [DW-1:0] col1, row1, bin1, band1;
   logic          adv_col, col_wrap, adv_row, row_wrap;

   always_comb begin
      col1     = col_ff + DW'(1);
      row1     = row_ff + DW'(1);
      bin1     = bin_ff + DW'(1);
      band1    = band_ff + DW'(1);
      adv_col  = (col1 >= ncb_ff);
      col_wrap = adv_col && ((col1 >= sw) || (bin1 >= dw));
      adv_row  = col_wrap && (row1 >= nrb_ff);
      row_wrap = adv_row && ((row1 >= sh) || (band1 >= dh));
      col_in   = col_ff;
      row_in   = row_ff;
      bin_in   = bin_ff;
      band_in  = band_ff;
      cs_in    = cs_ff;
      rs_in    = rs_ff;
      if (cfg_hit) begin
         col_in  = '0;
         row_in  = '0;
         bin_in  = '0;
         band_in = '0;
         cs_in   = '0;
         rs_in   = '0;
      end else if (cmd.advance) begin
         col_in = col1;
         if (adv_col) begin
            if (col_wrap) begin
               col_in = '0;
               bin_in = '0;
               cs_in  = '0;
               row_in = row1;
               if (adv_row) begin
                  if (row_wrap) begin
                     row_in  = '0;
                     band_in = '0;
                     rs_in   = '0;
                  end else begin
                     band_in = band1;
                     rs_in   = nrb_ff;
                  end
               end
            end else begin
               bin_in = bin1;
               cs_in  = ncb_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         bin_ff  <= '0;
         band_ff <= '0;
         cs_ff   <= '0;
         rs_ff   <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         bin_ff  <= bin_in;
         band_ff <= band_in;
         cs_ff   <= cs_in;
         rs_ff   <= rs_in;
      end
   end

   // bin accumulators
   logic [SW-1:0] ram_rd;
   logic [SW-1:0] sum_ff, sum_in;
   logic          first_px;

   assign first_px = (row_ff == rs_ff) && (col_ff == cs_ff);
   assign sum_in   = first_px ? SW'(luma_ff) : ram_rd + SW'(luma_ff);

   lbas_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_DIM)
   ) u_bins (
      .clock   (clock),
      .wr_en   (cmd.sum_en),
      .wr_addr (bin_ff[AW-1:0]),
      .wr_data (sum_in),
      .rd_addr (bin_ff[AW-1:0]),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         sum_ff <= sum_in;
      end
   end

   // shared multiplier: cell area or boundary product
   logic [DW-1:0] mul_a, mul_b, bound_p;
   logic [PW-1:0] prod_ff;

   always_comb begin
      case (cmd.op)
         lbas_pkg::OP_ROW: begin
            mul_a   = band1;
            mul_b   = sh;
            bound_p = dh;
         end
         lbas_pkg::OP_COL: begin
            mul_a   = bin1;
            mul_b   = sw;
            bound_p = dw;
         end
         default: begin
            mul_a   = ncb_ff - cs_ff;
            mul_b   = nrb_ff - rs_ff;
            bound_p = dw;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= PW'(mul_a) * PW'(mul_b);
      end
   end

   // shared divider: rounded average, bin start or band start
   logic [NW-1:0]   div_num, div_quo;
   logic [DENW-1:0] div_den;
   logic            div_busy, div_done;

   always_comb begin
      if (cmd.op == lbas_pkg::OP_CNT) begin
         div_num = NW'({sum_ff, 1'b0}) + NW'(prod_ff);
         div_den = (prod_ff == '0) ? DENW'(2) : {prod_ff, 1'b0};
      end else begin
         div_num = NW'({prod_ff, 1'b0}) + NW'(bound_p);
         div_den = DENW'({bound_p, 1'b0});
      end
   end

   lbas_div #(
      .NW   (NW),
      .DENW (DENW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_bound) begin
         if (cmd.op == lbas_pkg::OP_ROW) begin
            nrb_ff <= div_quo[DW-1:0];
         end else begin
            ncb_ff <= div_quo[DW-1:0];
         end
      end
   end

   // result register
   logic                                rsp_valid_ff;
   logic [lbas_pkg::CHAR_W-1:0]         char_ff;
   logic                                row_end_ff, image_end_ff;
   logic [lbas_pkg::LEVEL_W-1:0]        level, shade_idx;
   logic [lbas_pkg::AVG_W-1:0]          avg;
   logic                                out_free, row_end_c;

   assign avg       = div_quo[lbas_pkg::AVG_W-1:0];
   assign level     = avg[lbas_pkg::AVG_W-1 -: lbas_pkg::LEVEL_W];
   assign shade_idx = inverted_ff ? lbas_pkg::LEVEL_W'(lbas_pkg::SHADE_COUNT - 1) - level
                                  : level;
   assign row_end_c = (bin1 == dw);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         char_ff      <= lbas_pkg::shade_char(shade_idx);
         row_end_ff   <= row_end_c;
         image_end_ff <= row_end_c && (band1 == dh);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_shade_char = char_ff;
   assign rsp_row_end    = row_end_ff;
   assign rsp_image_end  = image_end_ff;

   always_comb begin
      status.cfg_hit  = cfg_hit;
      status.is_last  = (row1 == nrb_ff) && (col1 == ncb_ff);
      status.out_free = out_free;
      status.adv_col  = adv_col;
      status.adv_row  = adv_row;
      status.div_done = div_done;
      status.div_busy = div_busy;
   end

   // checks
   a_pos_in_cell: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> (col_ff < ncb_ff) && (row_ff < nrb_ff) && (bin_ff < dw))
      else $error("pixel position beyond current cell boundaries");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result written over an untaken result");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.emit))
      else $error("result valid without an emit command");

endmodule

`default_nettype wire

/* rtl/lbas_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module lbas_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire lbas_pkg::lbas_status_type  status,
   output lbas_pkg::lbas_cmd_type          cmd
);

   lbas_pkg::lbas_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbas_pkg::ST_ROW_MUL;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.op         = lbas_pkg::OP_CNT;
      req_ready      = 1'b0;
      case (state_ff)
         lbas_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = lbas_pkg::ST_LUMA;
            end
         end
         lbas_pkg::ST_LUMA: begin
            cmd.luma_en = 1'b1;
            state_in    = lbas_pkg::ST_SUM;
         end
         lbas_pkg::ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = status.is_last ? lbas_pkg::ST_CNT_MUL : lbas_pkg::ST_ADV;
         end
         lbas_pkg::ST_CNT_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = lbas_pkg::ST_AVG_GO;
         end
         lbas_pkg::ST_AVG_GO: begin
            cmd.div_start = 1'b1;
            state_in      = lbas_pkg::ST_AVG_WAIT;
         end
         lbas_pkg::ST_AVG_WAIT: begin
            if (status.div_done) begin
               state_in = lbas_pkg::ST_EMIT;
            end
         end
         lbas_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = lbas_pkg::ST_ADV;
            end
         end
         lbas_pkg::ST_ADV: begin
            cmd.advance = 1'b1;
            if (status.adv_row) begin
               state_in = lbas_pkg::ST_ROW_MUL;
            end else if (status.adv_col) begin
               state_in = lbas_pkg::ST_COL_MUL;
            end else begin
               state_in = lbas_pkg::ST_IDLE;
            end
         end
         lbas_pkg::ST_ROW_MUL: begin
            cmd.op     = lbas_pkg::OP_ROW;
            cmd.mul_en = 1'b1;
            state_in   = lbas_pkg::ST_ROW_GO;
         end
         lbas_pkg::ST_ROW_GO: begin
            cmd.op        = lbas_pkg::OP_ROW;
            cmd.div_start = 1'b1;
            state_in      = lbas_pkg::ST_ROW_WAIT;
         end
         lbas_pkg::ST_ROW_WAIT: begin
            cmd.op = lbas_pkg::OP_ROW;
            if (status.div_done) begin
               cmd.load_bound = 1'b1;
               state_in       = lbas_pkg::ST_COL_MUL;
            end
         end
         lbas_pkg::ST_COL_MUL: begin
            cmd.op     = lbas_pkg::OP_COL;
            cmd.mul_en = 1'b1;
            state_in   = lbas_pkg::ST_COL_GO;
         end
         lbas_pkg::ST_COL_GO: begin
            cmd.op        = lbas_pkg::OP_COL;
            cmd.div_start = 1'b1;
            state_in      = lbas_pkg::ST_COL_WAIT;
         end
         lbas_pkg::ST_COL_WAIT: begin
            cmd.op = lbas_pkg::OP_COL;
            if (status.div_done) begin
               cmd.load_bound = 1'b1;
               state_in       = lbas_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lbas_pkg::ST_ROW_MUL;
         end
      endcase
      // a register write restarts the image and recomputes both boundaries
      if (status.cfg_hit) begin
         req_ready      = 1'b0;
         cmd.accept     = 1'b0;
         cmd.sum_en     = 1'b0;
         cmd.emit       = 1'b0;
         cmd.advance    = 1'b0;
         cmd.load_bound = 1'b0;
         state_in       = lbas_pkg::ST_ROW_MUL;
      end
   end

   // checks
   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lbas_pkg::ST_IDLE) |-> !status.div_busy)
      else $error("divider still running while waiting for a pixel");

   a_emit_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !status.div_busy)
      else $error("emit while divider busy");

endmodule

`default_nettype wire

/* rtl/luma_box_downscale_ascii_shade.sv */
`timescale 1ns / 1ps
`default_nettype none

// Takes RGB pixels in raster order, forms integer luma, area-averages it over
// output cells (bins of columns, bands of rows) and returns one shade character
// per cell, with row and image end flags. One pixel is worked on at a time: a
// pixel that closes a bin also waits for the next bin start, one that closes a
// band also waits for the next band start, and one that closes a cell also
// waits for the rounded average, each from the shared restoring divider (one
// quotient bit a cycle, 30 bits at MAX_DIM 1024). After reset and after every
// register write the block computes the first band and bin ends before it
// takes a pixel. Register writes are taken at any time and restart the image.
module luma_box_downscale_ascii_shade #(
   parameter int MAX_DIM = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [lbas_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lbas_pkg::CFG_W-1:0]     csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [lbas_pkg::PIX_W-1:0]     req_red,
   input  wire logic [lbas_pkg::PIX_W-1:0]     req_green,
   input  wire logic [lbas_pkg::PIX_W-1:0]     req_blue,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [lbas_pkg::CHAR_W-1:0]         rsp_shade_char,
   output logic                                rsp_row_end,
   output logic                                rsp_image_end
);

   lbas_pkg::lbas_cmd_type    cmd;
   lbas_pkg::lbas_status_type status;

   lbas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lbas_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_shade_char (rsp_shade_char),
      .rsp_row_end    (rsp_row_end),
      .rsp_image_end  (rsp_image_end)
   );

endmodule

`default_nettype wire
